@@ src/apsp_nh_pkg.sv @@
// shared types and constants for the all-pairs shortest path next-hop engine
package apsp_nh_pkg;

  localparam int unsigned MaxNodesDefault = 64;

  localparam int unsigned DistW = 30;
  localparam int unsigned HopW  = 7;
  localparam int unsigned NodeW = 6;
  localparam int unsigned CountW = 7;

  localparam logic [DistW-1:0]        Unreach = 30'h3fff_ffff;
  localparam logic signed [HopW-1:0]  NoHop   = -7'sd1;
  localparam logic [CountW-1:0]       NodeCountRst = 7'd64;

  // apb register map
  localparam int unsigned PaddrW = 3;
  localparam logic        RegNodeCount = 1'b0;

  typedef enum logic [1:0] {
    ActClear   = 2'd0,
    ActAddEdge = 2'd1,
    ActCompute = 2'd2,
    ActQuery   = 2'd3
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [NodeW-1:0]   src_node;
    logic [NodeW-1:0]   dst_node;
    logic [DistW-1:0]   edge_length;
  } in_item_t;

  typedef struct packed {
    logic signed [HopW-1:0] next_hop;
    logic [DistW-1:0]       path_length;
    logic                   bad_node;
  } out_item_t;

  typedef struct packed {
    logic signed [HopW-1:0] hop;
    logic [DistW-1:0]       distance;
  } tbl_entry_t;

endpackage

@@ src/all_pairs_shortest_path_next_hop.sv @@
// all-pairs shortest path engine (floyd-warshall) with next-hop table
//
// The distance and next-hop tables share one synchronous memory of
// 2^(2*ceil(log2(MAX_NODES))) entries (4096 at 64 nodes), one write port and
// two read ports, read data registered. After reset the block sweeps the
// whole memory to the unreachable value and no next hop, one entry a cycle;
// input items wait for it, apb writes do not. Item handling: clear sweeps
// the memory the same way and then answers; add edge and query read one
// entry and answer from the registered read data; an item with a bad node
// answers without reading the memory. Compute walks k, then i, then j over
// n = min(node_count, MAX_NODES) live nodes: each row first fetches
// distance(i, k) in S_ROW and S_ROWW, then walks its columns only when
// that distance is reachable; unreachable rows are skipped. The column walk
// is a two-stage memory loop: read distance(i, j) and distance(k, j), then
// add, compare and write back distance(i, j). One item is in flight at a
// time and a new item is taken once the previous result has been handed
// off. node_count is written through apb register 0.
module all_pairs_shortest_path_next_hop #(
  parameter int unsigned MAX_NODES = apsp_nh_pkg::MaxNodesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  apsp_nh_pkg::in_item_t           in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output apsp_nh_pkg::out_item_t          out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [apsp_nh_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // node index width and table geometry
  localparam int unsigned NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned AW    = 2 * NW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CW0   = $clog2(MAX_NODES + 1);
  localparam int unsigned CW    = (CW0 > apsp_nh_pkg::CountW) ? CW0 : apsp_nh_pkg::CountW;

  // controller states
  localparam logic [2:0] S_CLR  = 3'd0;  // memory sweep
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;  // add edge, entry read back
  localparam logic [2:0] S_QRY  = 3'd3;  // query, entry read back
  localparam logic [2:0] S_ROW  = 3'd4;  // fetch distance(i, k)
  localparam logic [2:0] S_ROWW = 3'd5;  // distance(i, k) arrives
  localparam logic [2:0] S_RUN  = 3'd6;  // column walk

  logic [2:0] state_q, state_d;

  // table memory
  apsp_nh_pkg::tbl_entry_t mem_q [DEPTH];
  apsp_nh_pkg::tbl_entry_t rd_a_q, rd_b_q, wr_data;
  logic [AW-1:0]           rd_a_addr, rd_b_addr, wr_addr;
  logic                    wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[rd_a_addr];
    rd_b_q <= mem_q[rd_b_addr];
  end

  // configuration register
  logic [apsp_nh_pkg::CountW-1:0] node_count_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == apsp_nh_pkg::RegNodeCount);
  assign prdata = (paddr[2] == apsp_nh_pkg::RegNodeCount)
                ? {{(32 - apsp_nh_pkg::CountW){1'b0}}, node_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= apsp_nh_pkg::NodeCountRst;
    end else if (cfg_wr) begin
      node_count_q <= pwdata[apsp_nh_pkg::CountW-1:0];
    end
  end

  // live node count, saturated at the table size
  logic [CW-1:0] nc_ext, cnt, cnt_m1;
  assign nc_ext = CW'(node_count_q);
  assign cnt    = (nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext;
  assign cnt_m1 = cnt - CW'(1);

  // item and loop state
  apsp_nh_pkg::in_item_t   req_q, req_d;
  logic [NW-1:0]           k_q, k_d, i_q, i_d, j_q, j_d;
  logic [AW-1:0]           clr_addr_q, clr_addr_d;
  logic                    clr_rsp_q, clr_rsp_d;
  logic [apsp_nh_pkg::DistW-1:0]        dik_q, dik_d;
  logic signed [apsp_nh_pkg::HopW-1:0]  hik_q, hik_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  apsp_nh_pkg::out_item_t  out_item_q, out_item_d;
  logic                    rsp_set;
  apsp_nh_pkg::out_item_t  rsp;

  logic                    in_fire, bad, row_end, relax;
  logic                    i_last, k_last, j_last;
  logic [apsp_nh_pkg::DistW:0] sum;
  logic [NW-1:0]           src_idx, dst_idx;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign bad = (CW'(in_item_i.src_node) >= cnt) || (CW'(in_item_i.dst_node) >= cnt);
  assign src_idx = NW'(in_item_i.src_node);
  assign dst_idx = NW'(in_item_i.dst_node);

  assign i_last = (CW'(i_q) == cnt_m1);
  assign k_last = (CW'(k_q) == cnt_m1);
  assign j_last = (CW'(j_q) == cnt_m1);

  // relaxation through k: rd_a holds distance(i, j), rd_b holds distance(k, j)
  assign sum   = {1'b0, dik_q} + {1'b0, rd_b_q.distance};
  assign relax = (sum < {1'b0, apsp_nh_pkg::Unreach}) && ({1'b0, rd_a_q.distance} > sum);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    k_d        = k_q;
    i_d        = i_q;
    j_d        = j_q;
    clr_addr_d = clr_addr_q;
    clr_rsp_d  = clr_rsp_q;
    dik_d      = dik_q;
    hik_d      = hik_q;
    rd_a_addr  = {i_q, k_q};
    rd_b_addr  = {k_q, j_q};
    wr_en      = 1'b0;
    wr_addr    = clr_addr_q;
    wr_data    = '{hop: apsp_nh_pkg::NoHop, distance: apsp_nh_pkg::Unreach};
    rsp_set    = 1'b0;
    rsp        = '{next_hop: apsp_nh_pkg::NoHop, path_length: '0, bad_node: 1'b0};
    row_end    = 1'b0;

    unique case (state_q)
      S_CLR: begin
        wr_en = 1'b1;
        if (&clr_addr_q) begin
          state_d = S_IDLE;
          rsp_set = clr_rsp_q;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_d = in_item_i;
          unique case (in_item_i.action)
            apsp_nh_pkg::ActClear: begin
              clr_addr_d = '0;
              clr_rsp_d  = 1'b1;
              state_d    = S_CLR;
            end
            apsp_nh_pkg::ActAddEdge, apsp_nh_pkg::ActQuery: begin
              if (bad) begin
                rsp_set      = 1'b1;
                rsp.bad_node = 1'b1;
              end else begin
                rd_a_addr = {src_idx, dst_idx};
                state_d   = (in_item_i.action == apsp_nh_pkg::ActQuery) ? S_QRY : S_ADD;
              end
            end
            apsp_nh_pkg::ActCompute: begin
              if (cnt == '0) begin
                rsp_set = 1'b1;
              end else begin
                k_d     = '0;
                i_d     = '0;
                state_d = S_ROW;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        // parallel edges keep the shorter length
        if (req_q.edge_length < rd_a_q.distance) begin
          wr_en   = 1'b1;
          wr_addr = {NW'(req_q.src_node), NW'(req_q.dst_node)};
          wr_data = '{hop: $signed({1'b0, req_q.dst_node}), distance: req_q.edge_length};
        end
        rsp_set = 1'b1;
        state_d = S_IDLE;
      end
      S_QRY: begin
        rsp_set         = 1'b1;
        rsp.next_hop    = rd_a_q.hop;
        rsp.path_length = rd_a_q.distance;
        state_d         = S_IDLE;
      end
      S_ROW: begin
        rd_a_addr = {i_q, k_q};
        state_d   = S_ROWW;
      end
      S_ROWW: begin
        dik_d = rd_a_q.distance;
        hik_d = rd_a_q.hop;
        if (rd_a_q.distance >= apsp_nh_pkg::Unreach) begin
          row_end = 1'b1;
        end else begin
          rd_a_addr = {i_q, {NW{1'b0}}};
          rd_b_addr = {k_q, {NW{1'b0}}};
          j_d       = '0;
          state_d   = S_RUN;
        end
      end
      S_RUN: begin
        if (relax) begin
          wr_en   = 1'b1;
          wr_addr = {i_q, j_q};
          wr_data = '{hop: hik_q, distance: sum[apsp_nh_pkg::DistW-1:0]};
        end
        if (j_last) begin
          row_end = 1'b1;
        end else begin
          rd_a_addr = {i_q, j_q + NW'(1)};
          rd_b_addr = {k_q, j_q + NW'(1)};
          j_d       = j_q + NW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // step to the next row, then to the next intermediate node
    if (row_end) begin
      priority if (i_last && k_last) begin
        rsp_set = 1'b1;
        state_d = S_IDLE;
      end else if (i_last) begin
        k_d     = k_q + NW'(1);
        i_d     = '0;
        state_d = S_ROW;
      end else begin
        i_d     = i_q + NW'(1);
        state_d = S_ROW;
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    if (rsp_set) begin
      out_valid_d = 1'b1;
      out_item_d  = rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_addr_q  <= '0;
      clr_rsp_q   <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clr_rsp_q   <= clr_rsp_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    dik_q      <= dik_d;
    hik_q      <= hik_d;
    out_item_q <= out_item_d;
  end

  // an accepted item either starts work or answers on the next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_valid_q || state_q != S_IDLE))
    else $error("accepted item neither answered nor started");

  // the table is written only by the sweep, add edge or relaxation
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_CLR || state_q == S_ADD || state_q == S_RUN))
    else $error("table write outside a writing state");

  // relaxation never stores an unreachable sum
  a_relax_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == S_RUN) |-> (wr_data.distance < apsp_nh_pkg::Unreach))
    else $error("relaxation wrote an unreachable distance");

  // a pending result is never overwritten
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !rsp_set)
    else $error("result produced while previous one pending");

endmodule

@@ verif/all_pairs_shortest_path_next_hop_test.sv @@
// self-checking testbench for the all-pairs shortest path next-hop engine
`timescale 1ns / 1ps

module all_pairs_shortest_path_next_hop_test;

  // table geometry matches the block's default build
  localparam int unsigned Nodes = apsp_nh_pkg::MaxNodesDefault;
  localparam int unsigned Cells = Nodes * Nodes;
  localparam int unsigned CellW = $clog2(Cells);
  localparam int unsigned DistW = apsp_nh_pkg::DistW;
  localparam int unsigned HopW = apsp_nh_pkg::HopW;
  localparam int unsigned NodeW = apsp_nh_pkg::NodeW;
  localparam int unsigned CountW = apsp_nh_pkg::CountW;
  localparam int unsigned PaddrW = apsp_nh_pkg::PaddrW;
  localparam logic [PaddrW-1:0] NodeCountAddr = {apsp_nh_pkg::RegNodeCount, 2'b00};
  localparam int unsigned RandPhases = 6;
  localparam int unsigned ItemsPerPhase = 12;
  localparam int unsigned MaxReports = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // item channels
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  apsp_nh_pkg::in_item_t  in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  apsp_nh_pkg::out_item_t out_item;

  // register port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // traffic shaping, percent of cycles spent idle on each side
  int unsigned tx_idle_pct = 34;
  int unsigned rx_idle_pct = 77;
  logic        hold_rx = 1'b0;

  // shadow of the graph tables and of the node count register
  logic [DistW-1:0]       dist_tbl [Cells];
  logic signed [HopW-1:0] hop_tbl [Cells];
  logic [CountW-1:0]      node_count_cfg = apsp_nh_pkg::NodeCountRst;

  apsp_nh_pkg::in_item_t  pending_items[$];
  apsp_nh_pkg::out_item_t expected_results[$];
  apsp_nh_pkg::out_item_t head_res;
  int unsigned results_seen = 0;
  int unsigned fail_cnt = 0;

  all_pairs_shortest_path_next_hop u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // shadow model of the engine
  // ---------------------------------------------------------------------------

  // flat table index of (row, col)
  function automatic logic [CellW-1:0] cell_at(int unsigned row, int unsigned col);
    return CellW'(row * Nodes + col);
  endfunction

  function automatic void clear_graph();
    for (int p = 0; p < Cells; p++) begin
      dist_tbl[CellW'(p)] = apsp_nh_pkg::Unreach;
      hop_tbl[CellW'(p)]  = apsp_nh_pkg::NoHop;
    end
  endfunction

  // in-place relaxation, k outer, i middle, j inner; rows that cannot reach k
  // are skipped and sums at or past the unreachable value never land
  function automatic void relax_graph(int unsigned n);
    logic [DistW:0] sum;
    for (int unsigned k = 0; k < n; k++) begin
      for (int unsigned i = 0; i < n; i++) begin
        if (dist_tbl[cell_at(i, k)] >= apsp_nh_pkg::Unreach) continue;
        for (int unsigned j = 0; j < n; j++) begin
          sum = {1'b0, dist_tbl[cell_at(i, k)]} + {1'b0, dist_tbl[cell_at(k, j)]};
          if (sum < {1'b0, apsp_nh_pkg::Unreach} && dist_tbl[cell_at(i, j)] > sum) begin
            dist_tbl[cell_at(i, j)] = sum[DistW-1:0];
            hop_tbl[cell_at(i, j)]  = hop_tbl[cell_at(i, k)];
          end
        end
      end
    end
  endfunction

  // applies one item to the shadow tables and returns the result it must give
  function automatic apsp_nh_pkg::out_item_t apply_graph_item(apsp_nh_pkg::in_item_t it);
    apsp_nh_pkg::out_item_t res;
    int unsigned n;
    int unsigned s;
    int unsigned d;
    res.next_hop    = apsp_nh_pkg::NoHop;
    res.path_length = '0;
    res.bad_node    = 1'b0;
    // counts above the table size saturate
    n = (node_count_cfg > CountW'(Nodes)) ? Nodes : 32'(node_count_cfg);
    s = 32'(it.src_node);
    d = 32'(it.dst_node);
    case (it.action)
      apsp_nh_pkg::ActClear: begin
        clear_graph();
      end
      apsp_nh_pkg::ActCompute: begin
        relax_graph(n);
      end
      default: begin
        res.bad_node = (s >= n) || (d >= n);
        if (!res.bad_node) begin
          if (it.action == apsp_nh_pkg::ActAddEdge) begin
            // parallel edges: only a strictly shorter one replaces
            if (it.edge_length < dist_tbl[cell_at(s, d)]) begin
              dist_tbl[cell_at(s, d)] = it.edge_length;
              hop_tbl[cell_at(s, d)]  = $signed(HopW'(d));
            end
          end else begin
            res.next_hop    = hop_tbl[cell_at(s, d)];
            res.path_length = dist_tbl[cell_at(s, d)];
          end
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_item(apsp_nh_pkg::action_e act, int unsigned s,
                                     int unsigned d, logic [DistW-1:0] len);
    apsp_nh_pkg::in_item_t it;
    it.action      = act;
    it.src_node    = NodeW'(s);
    it.dst_node    = NodeW'(d);
    it.edge_length = len;
    pending_items.insert(pending_items.size(), it);
  endfunction

  // mostly short lengths so paths combine, plus the extremes and wide values
  function automatic logic [DistW-1:0] pick_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return apsp_nh_pkg::Unreach;
      2:       return apsp_nh_pkg::Unreach - DistW'(1);
      3, 4:    return DistW'($urandom);
      default: return DistW'($urandom_range(1, 20));
    endcase
  endfunction

  // well-formed graph traffic over live nodes, with some bad nodes and noise
  function automatic apsp_nh_pkg::in_item_t pick_item(int unsigned n);
    apsp_nh_pkg::in_item_t it;
    int unsigned r;
    int unsigned far_node;
    it.src_node    = NodeW'($urandom_range(n - 1));
    it.dst_node    = NodeW'($urandom_range(n - 1));
    it.edge_length = DistW'($urandom);
    it.action      = apsp_nh_pkg::ActQuery;
    r = $urandom_range(99);
    if (r < 45) begin
      it.action      = apsp_nh_pkg::ActAddEdge;
      it.edge_length = pick_length();
    end else if (r < 78) begin
      it.action = apsp_nh_pkg::ActQuery;
    end else if (r < 86) begin
      it.action = apsp_nh_pkg::ActCompute;
    end else if (r < 89) begin
      it.action = apsp_nh_pkg::ActClear;
    end else if (r < 95 && n < Nodes) begin
      // node index at or above the live count
      it.action = $urandom_range(1) ? apsp_nh_pkg::ActAddEdge : apsp_nh_pkg::ActQuery;
      far_node  = $urandom_range(Nodes - 1, n);
      if ($urandom_range(1)) it.src_node = NodeW'(far_node);
      else it.dst_node = NodeW'(far_node);
    end else begin
      it.action   = apsp_nh_pkg::action_e'(2'($urandom_range(3)));
      it.src_node = NodeW'($urandom_range(Nodes - 1));
      it.dst_node = NodeW'($urandom_range(Nodes - 1));
    end
    return it;
  endfunction

  // sender holds back until every queued item has been answered; sampled on
  // the falling edge so the driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // two-phase register write; lands on the access edge since pready stays high
  task automatic write_node_count(input logic [CountW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NodeCountAddr;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    node_count_cfg = val;
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued items, random gaps between them
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else if (!in_valid || in_ready) begin
      // slot is free: either nothing was offered or the item just went in
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on input handshakes, checks on output handshakes;
  // both in one block so an item answered on its own edge stays ordered
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), apply_graph_item(in_item));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports) begin
            $display("unexpected result item: hop %0d len %h bad %b",
                     out_item.next_hop, out_item.path_length, out_item.bad_node);
          end
        end else begin
          head_res = expected_results.pop_front();
          if (out_item.next_hop !== head_res.next_hop ||
              out_item.path_length !== head_res.path_length ||
              out_item.bad_node !== head_res.bad_node) begin
            fail_cnt++;
            if (fail_cnt <= MaxReports) begin
              $display("result %0d mismatch: hop %0d/%0d len %h/%h bad %b/%b (exp/got)",
                       results_seen, head_res.next_hop, out_item.next_hop,
                       head_res.path_length, out_item.path_length,
                       head_res.bad_node, out_item.bad_node);
            end
          end
        end
      end
      out_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver stall: the result backs up and the block refuses new items
  initial begin
    wait (results_seen >= 45);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // hard stop if the run hangs
  initial begin
    #18_000_000;
    $display("[all_pairs_shortest_path_next_hop] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned n;
    clear_graph();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full-size graph after reset, node count 64
    queue_item(apsp_nh_pkg::ActQuery, 0, 0, '0);     // empty table reads back unreachable
    queue_item(apsp_nh_pkg::ActAddEdge, 0, 63, '0);  // zero-length edge to the top node
    queue_item(apsp_nh_pkg::ActAddEdge, 63, 0, apsp_nh_pkg::Unreach);  // never lands
    queue_item(apsp_nh_pkg::ActAddEdge, 63, 0, apsp_nh_pkg::Unreach - DistW'(1));
    queue_item(apsp_nh_pkg::ActAddEdge, 0, 63, 30'd5);  // longer parallel edge is dropped
    queue_item(apsp_nh_pkg::ActAddEdge, 5, 5, 30'd7);   // self loop
    queue_item(apsp_nh_pkg::ActQuery, 0, 63, '0);
    queue_item(apsp_nh_pkg::ActCompute, 0, 0, apsp_nh_pkg::Unreach);
    queue_item(apsp_nh_pkg::ActQuery, 0, 0, '0);     // diagonal holds the shortest cycle
    queue_item(apsp_nh_pkg::ActQuery, 63, 63, '0);
    queue_item(apsp_nh_pkg::ActQuery, 5, 5, '0);
    wait_drained();

    // node count zero: every edge and query is flagged, compute is a no-op
    write_node_count(7'd0);
    queue_item(apsp_nh_pkg::ActAddEdge, 0, 0, 30'd1);
    queue_item(apsp_nh_pkg::ActQuery, 0, 0, '0);
    queue_item(apsp_nh_pkg::ActCompute, 0, 0, '0);
    wait_drained();

    // count beyond the table size saturates; clear wipes everything
    write_node_count(7'd127);
    queue_item(apsp_nh_pkg::ActQuery, 63, 63, '0);
    queue_item(apsp_nh_pkg::ActClear, 63, 63, apsp_nh_pkg::Unreach);
    queue_item(apsp_nh_pkg::ActQuery, 63, 63, '0);
    wait_drained();

    // sums that reach the unreachable value must not update
    write_node_count(7'd3);
    queue_item(apsp_nh_pkg::ActAddEdge, 0, 1, 30'h2000_0000);
    queue_item(apsp_nh_pkg::ActAddEdge, 1, 2, 30'h2000_0000);
    queue_item(apsp_nh_pkg::ActAddEdge, 2, 0, 30'd1);
    queue_item(apsp_nh_pkg::ActCompute, 0, 0, '0);
    queue_item(apsp_nh_pkg::ActQuery, 0, 2, '0);
    queue_item(apsp_nh_pkg::ActQuery, 2, 1, '0);
    queue_item(apsp_nh_pkg::ActAddEdge, 3, 0, 30'd1);  // node equal to the count is bad
    wait_drained();

    // smallest live graph
    write_node_count(7'd1);
    queue_item(apsp_nh_pkg::ActAddEdge, 0, 0, '0);
    queue_item(apsp_nh_pkg::ActQuery, 1, 0, '0);
    wait_drained();

    // random phases: each starts from a clean table at a fresh node count;
    // two phases per idle pattern, the last pair with no idling at all
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 77;
        end
        1: begin
          tx_idle_pct = 77;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // one sparse phase at full size, the others stay small to keep compute short
      n = (ph == 3) ? Nodes : $urandom_range(9, 2);
      write_node_count(CountW'(n));
      queue_item(apsp_nh_pkg::ActClear, 0, 0, '0);
      for (int q = 0; q < ItemsPerPhase; q++) begin
        pending_items.insert(pending_items.size(), pick_item(n));
      end
      wait_drained();
    end

    // catch any stray result
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[all_pairs_shortest_path_next_hop] OK");
    end else begin
      $display("[all_pairs_shortest_path_next_hop] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/apsp_nh_pkg.sv
src/all_pairs_shortest_path_next_hop.sv
verif/all_pairs_shortest_path_next_hop_test.sv
